// ===== rtl/rmvn_pkg.sv =====
// Package for the running mean/variance normalizer.
// Holds the item kind codes, the controller state type, the command and status structs and the fixed field widths.
`default_nettype none
package rmvn_pkg;
    localparam int SampleWidth = 32;
    localparam int SumWidth    = 64;

    typedef enum logic {
        KIND_TRACK     = 1'b0,
        KIND_NORMALIZE = 1'b1
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_DIV_START,
        ST_T_DIV_WAIT,
        ST_T_MUL,
        ST_T_ACC,
        ST_N_CHECK,
        ST_N_VAR_WAIT,
        ST_N_SQRT_WAIT,
        ST_N_Z_START,
        ST_N_Z_WAIT,
        ST_N_DONE,
        ST_OUT
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;        // capture input beat
        logic cnt_inc;     // advance saturating count
        logic div_mean;    // start divide |d1| / n
        logic mean_upd;    // apply quotient to mean
        logic mul;         // form |d1|*|d2|
        logic acc;         // accumulate into m2
        logic div_var;     // start divide m2 / (n-1)
        logic sqrt_start;  // start integer square root
        logic div_z;       // start divide num / sd
        logic z_upd;       // capture z-score result
        logic z_undef;     // force undefined-spread result
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic kind;
        logic busy;        // divider or root unit running
        logic spread_bad;  // count below two or m2 zero
        logic sd_zero;
    } stat_t;
endpackage
`default_nettype wire

// ===== rtl/rmvn_if.sv =====
// Valid/ready channel interface carrying one payload.
// Depends on nothing; payload type given as a parameter.
`default_nettype none
interface rmvn_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/running_mean_variance_normalizer.sv =====
// Top level of the running mean/variance normalizer (Welford statistics).
// Depends on rmvn_pkg, rmvn_if, rmvn_ctrl and rmvn_datapath.
//
// Usage: the input channel carries beats of {kind, sample}. A track beat
// (kind 0) folds its Q16.16 sample into a saturating count, a running mean and
// a 64-bit sum of squared deviations, and produces no output beat. A normalize
// beat (kind 1) produces one output beat {zscore, spread_zero}: the Q16.16
// z-score of its sample against the current statistics, saturated, or zero
// with spread_zero set when fewer than two samples were tracked or the
// deviation is zero.
// Sequencing: one item is worked at a time, and the idle cycle that takes the next
// beat follows each item. A track item runs one bit-serial divide by the count
// on the divider, which is the wider of COUNT_WIDTH and 64 bits. A normalize item
// runs two divides on the shared one-bit-per-cycle divider and a square root;
// its result is offered sooner when the root truncates to zero, since the
// second divide is skipped, and soonest when the count or m2 leaves the
// spread undefined.
// Reset clears the statistics and the controller at once; the input is ready
// on the first cycle after reset. When the receiver stalls, the result holds
// in the output register while track beats keep flowing; the next normalize
// beat waits before computing until that result is taken, and the input then
// stalls behind it.
`default_nettype none
module running_mean_variance_normalizer
    import rmvn_pkg::*;
#(
    parameter int COUNT_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    rmvn_if.sink     in_ch,
    rmvn_if.source   out_ch
);
    cmd_t   cmd;
    stat_t  stat;
    logic   in_ready, out_valid;
    logic [SampleWidth-1:0] zscore;
    logic   spread_zero;

    rmvn_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ch.ready),
        .stat(stat), .cmd(cmd)
    );

    rmvn_datapath #(.COUNT_WIDTH(COUNT_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_kind(in_ch.data.kind), .in_sample(in_ch.data.sample),
        .zscore(zscore), .spread_zero(spread_zero)
    );

    assign in_ch.ready             = in_ready;
    assign out_ch.valid            = out_valid;
    assign out_ch.data.zscore      = zscore;
    assign out_ch.data.spread_zero = spread_zero;

`ifndef ASSERT_OFF
    // A new result is only written when the output register is free or leaving.
    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.z_upd || cmd.z_undef) |-> (!out_valid || out_ch.ready))
        else $error("result written over a waiting beat");
    // A result is only shown after it was produced.
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.z_upd || cmd.z_undef, 2))
        else $error("result without production");
    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ch.ready |=> out_valid && $stable(zscore) && $stable(spread_zero))
        else $error("result changed under stall");
`endif
endmodule
`default_nettype wire

// ===== rtl/rmvn_div.sv =====
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Standalone; used by the datapath for all three divisions.
`default_nettype none
module rmvn_div #(
    parameter int W = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] num,
    input  wire logic [W-1:0] den,
    output logic              busy,
    output logic [W-1:0]      quot
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  den_reg;
    logic [CW-1:0] cnt_reg;
    logic [W:0]    trial;

    always_comb
    begin
        trial    = {rem_reg, q_reg[W-1]};
        rem_next = trial[W-1:0];
        q_next   = {q_reg[W-2:0], 1'b0};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next  = W'(trial - {1'b0, den_reg});
            q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= CW'(W);
        else if (cnt_reg != '0)
            cnt_reg <= cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= num;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;
endmodule
`default_nettype wire

// ===== rtl/rmvn_sqrt.sv =====
// Bit-pair integer square root of a 64-bit value, one result bit per cycle.
// Uses rmvn_pkg widths.
`default_nettype none
module rmvn_sqrt
    import rmvn_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [SumWidth-1:0] value,
    output logic                     busy,
    output logic [SumWidth/2-1:0]    root
);
    localparam int HW = SumWidth / 2;
    logic [SumWidth-1:0] v_reg;
    logic [HW+1:0]       rem_reg, rem_next;
    logic [HW-1:0]       r_reg, r_next;
    logic [5:0]          cnt_reg;
    logic [HW+1:0]       trial;

    always_comb
    begin
        rem_next = {rem_reg[HW-1:0], v_reg[SumWidth-1:SumWidth-2]};
        trial    = {r_reg, 2'b01};
        r_next   = {r_reg[HW-2:0], 1'b0};
        if (rem_next >= trial)
        begin
            rem_next  = rem_next - trial;
            r_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= 6'(HW);
        else if (cnt_reg != '0)
            cnt_reg <= cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= value;
            rem_reg <= '0;
            r_reg   <= '0;
        end
        else if (cnt_reg != '0)
        begin
            v_reg   <= {v_reg[SumWidth-3:0], 2'b00};
            rem_reg <= rem_next;
            r_reg   <= r_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign root = r_reg;
endmodule
`default_nettype wire

// ===== rtl/rmvn_datapath.sv =====
// Datapath: statistics registers, shared divider, square root and result register.
// Depends on rmvn_pkg, rmvn_div and rmvn_sqrt.
`default_nettype none
module rmvn_datapath
    import rmvn_pkg::*;
#(
    parameter int COUNT_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cmd_t                   cmd,
    output stat_t                       stat,
    input  wire logic                   in_kind,
    input  wire logic [SampleWidth-1:0] in_sample,
    output logic [SampleWidth-1:0]      zscore,
    output logic                        spread_zero
);
    localparam int DW = (COUNT_WIDTH > SumWidth) ? COUNT_WIDTH : SumWidth;

    logic [COUNT_WIDTH-1:0]   cnt_reg;
    logic [SampleWidth-1:0]   mean_reg;
    logic [SumWidth-1:0]      m2_reg;
    logic                     kind_reg;
    logic [SampleWidth:0]     x_reg;      // sign-extended sample
    logic                     neg_reg;
    logic [SampleWidth:0]     mag1_reg;   // |x - mean|
    logic [SumWidth-1:0]      prod_reg;
    logic [SampleWidth-1:0]   z_reg;
    logic                     zf_reg;
    logic [SumWidth/2-1:0]    sd_reg;

    logic [SampleWidth+1:0]   diff;
    logic [SampleWidth:0]     dmag;
    logic                     div_start, div_busy, sq_busy;
    logic [DW-1:0]            div_num, div_den, div_q;
    logic [SumWidth/2-1:0]    root;
    logic [SampleWidth+1:0]   mean_new;
    logic [SumWidth:0]        sum;
    logic [DW-1:0]            qz;

    assign diff = {x_reg[SampleWidth], x_reg} - {{2{mean_reg[SampleWidth-1]}}, mean_reg};
    assign dmag = diff[SampleWidth+1] ? (SampleWidth+1)'(0) - diff[SampleWidth:0]
                                      : diff[SampleWidth:0];
    assign div_start = cmd.div_mean | cmd.div_var | cmd.div_z;

    always_comb
    begin
        div_num = '0;
        div_den = '0;
        if (cmd.div_mean)
        begin
            div_num = DW'(dmag);
            div_den = DW'(cnt_reg);
        end
        else if (cmd.div_var)
        begin
            div_num = DW'(m2_reg);
            div_den = DW'(cnt_reg - 1'b1);
        end
        else
        begin
            div_num = DW'(dmag) << FRAC_BITS;
            div_den = DW'(sd_reg);
        end
    end

    rmvn_div #(.W(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(div_num), .den(div_den), .busy(div_busy), .quot(div_q)
    );

    rmvn_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(cmd.sqrt_start),
        .value(div_q[SumWidth-1:0]), .busy(sq_busy), .root(root)
    );

    assign mean_new = neg_reg
        ? {{2{mean_reg[SampleWidth-1]}}, mean_reg} - (SampleWidth+2)'(div_q)
        : {{2{mean_reg[SampleWidth-1]}}, mean_reg} + (SampleWidth+2)'(div_q);
    assign sum = {1'b0, m2_reg} + {1'b0, prod_reg};
    assign qz  = div_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            mean_reg <= '0;
            m2_reg   <= '0;
        end
        else
        begin
            if (cmd.cnt_inc && cnt_reg != '1)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.mean_upd)
                mean_reg <= mean_new[SampleWidth-1:0];
            if (cmd.acc)
                m2_reg <= sum[SumWidth] ? '1 : sum[SumWidth-1:0];
        end
    end

    // Both deviations are at most 2^32 - 1, so their low 32 bits hold them.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_kind;
            x_reg    <= {in_sample[SampleWidth-1], in_sample};
        end
        if (cmd.div_mean || cmd.div_z)
        begin
            neg_reg  <= diff[SampleWidth+1];
            mag1_reg <= dmag;
        end
        if (cmd.mul)
            prod_reg <= SumWidth'(mag1_reg[SampleWidth-1:0]) * SumWidth'(dmag[SampleWidth-1:0]);
        if (cmd.z_undef)
        begin
            z_reg  <= '0;
            zf_reg <= 1'b1;
        end
        else if (cmd.z_upd)
        begin
            zf_reg <= 1'b0;
            if (neg_reg)
                z_reg <= (qz > DW'(33'h080000000)) ? 32'h80000000
                         : SampleWidth'(DW'(0) - qz);
            else
                z_reg <= (qz > DW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : qz[SampleWidth-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
            sd_reg <= '0;
        else if (!sq_busy)
            sd_reg <= root;
    end

    assign stat.kind       = kind_reg;
    assign stat.busy       = div_busy | sq_busy;
    assign stat.spread_bad = (cnt_reg < COUNT_WIDTH'(2)) || (m2_reg == '0);
    assign stat.sd_zero    = (root == '0);
    assign zscore          = z_reg;
    assign spread_zero     = zf_reg;
endmodule
`default_nettype wire

// ===== rtl/rmvn_ctrl.sv =====
// Controller state machine sequencing track and normalize items.
// Depends on rmvn_pkg; drives the datapath through cmd_t.
`default_nettype none
module rmvn_ctrl
    import rmvn_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_T_DIV_START;
                end
            end
            ST_T_DIV_START:
            begin
                if (stat.kind == KIND_NORMALIZE)
                    state_next = ST_N_CHECK;
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_T_DIV_WAIT;
                end
            end
            ST_T_DIV_WAIT:
            begin
                cmd.div_mean = 1'b1;
                state_next   = ST_T_MUL;
            end
            ST_T_MUL:
            begin
                if (!stat.busy)
                begin
                    cmd.mean_upd = 1'b1;
                    state_next   = ST_T_ACC;
                end
            end
            ST_T_ACC:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_N_DONE;
            end
            ST_N_DONE:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_N_CHECK:
            begin
                // A normalize item starts only once the output register is free,
                // so the result it writes never lands on a beat still waiting.
                if (!out_valid_reg || out_ready)
                begin
                    if (stat.spread_bad)
                    begin
                        cmd.z_undef = 1'b1;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        cmd.div_var = 1'b1;
                        state_next  = ST_N_VAR_WAIT;
                    end
                end
            end
            ST_N_VAR_WAIT:
            begin
                if (!stat.busy)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_N_SQRT_WAIT;
                end
            end
            ST_N_SQRT_WAIT:
            begin
                if (!stat.busy)
                begin
                    if (stat.sd_zero)
                    begin
                        cmd.z_undef = 1'b1;
                        state_next  = ST_OUT;
                    end
                    else
                        state_next = ST_N_Z_START;
                end
            end
            ST_N_Z_START:
            begin
                cmd.div_z  = 1'b1;
                state_next = ST_N_Z_WAIT;
            end
            ST_N_Z_WAIT:
            begin
                if (!stat.busy)
                begin
                    cmd.z_upd  = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire
